@@ hdl/cae_pkg.sv @@
// Shared types and constants for the contiguous allocator with eviction.
// Used by the block table, the top level and the port checker.
`default_nettype none
package cae_pkg;

  localparam int MEM_UNITS = 64;
  localparam int MAX_PROCS = 16;
  localparam int CELL_W    = 6;
  localparam int ID_W      = 4;
  localparam int SIZE_W    = 7;
  localparam int STAMP_W   = 32;
  localparam int EVC_W     = 5;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_USE   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_ROOM  = 2'd2;
  localparam logic [1:0] ST_NOT_RES  = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ID_W-1:0]   process_id;
    logic [SIZE_W-1:0] request_units;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CELL_W-1:0] start_unit;
    logic [SIZE_W-1:0] freed_units;
    logic [EVC_W-1:0]  evicted_count;
  } out_item_t;

  // Write requests from the sequencer to the block table
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               res_we;
    logic               res_val;
    logic               place_we;
    logic [CELL_W-1:0]  start_val;
    logic [SIZE_W-1:0]  size_val;
    logic               arr_we;
    logic               lru_we;
    logic [STAMP_W-1:0] stamp_val;
    logic               shd_we;
    logic [ID_W-1:0]    shd_id;
    logic [CELL_W-1:0]  shd_val;
    logic               commit;
  } tab_wr_t;

endpackage
`default_nettype wire

@@ hdl/contiguous_allocator_with_eviction_unit.sv @@
// Top level: sequencer for allocate, free and use over a cell scan.
// Uses cae_pkg and cae_blocktab.
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_ready  | in_item_t
//   out_       | out | out_valid/out_ready| out_item_t
//   cfg_       | in  | cfg_we             | eviction policy bit
//
// Each first-fit search and each compaction walks all 64 cells one per cycle,
// and each eviction adds a victim scan over all 16 ids through one 32-bit
// comparator.
// One item is in work at a time; in_ready is low until its result is posted.
// Reset is synchronous; no clearing pass is needed. A result waits in the
// output register while out_ready is low and the sequencer holds.
`default_nettype none
module contiguous_allocator_with_eviction_unit
  import cae_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_FIT    = 4'd2;
  localparam logic [3:0] S_ARR    = 4'd3;
  localparam logic [3:0] S_LRU    = 4'd4;
  localparam logic [3:0] S_PICK   = 4'd5;
  localparam logic [3:0] S_EVICT  = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(MEM_UNITS - 1);
  localparam logic [ID_W-1:0]   LAST_ID   = ID_W'(MAX_PROCS - 1);

  logic [3:0]         state_r, state_nxt;
  logic               policy_r;
  in_item_t           req_r, req_nxt;
  logic               keep_r, keep_nxt;
  logic [CELL_W-1:0]  idx_r, idx_nxt;
  logic [SIZE_W-1:0]  run_r, run_nxt;
  logic [CELL_W-1:0]  first_r, first_nxt;
  logic [SIZE_W-1:0]  cursor_r, cursor_nxt;
  logic [ID_W-1:0]    pid_r, pid_nxt;
  logic [ID_W-1:0]    bid_r, bid_nxt;
  logic               found_r, found_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [STAMP_W-1:0] ctr_r, ctr_nxt;
  logic [EVC_W-1:0]   evc_r, evc_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  tab_wr_t              wr;
  logic [ID_W-1:0]      rd_id;
  logic [MAX_PROCS-1:0] resident;
  logic [SIZE_W-1:0]    rd_size, hit_size;
  logic [STAMP_W-1:0]   rd_arr, rd_lru, cand;
  logic                 cell_occ, start_hit;
  logic [ID_W-1:0]      hit_id;
  logic [SIZE_W-1:0]    run_inc;
  logic [STAMP_W-1:0]   ctr_inc;

  cae_blocktab u_tab (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .cell_idx  (idx_r),
    .rd_id     (rd_id),
    .resident  (resident),
    .rd_size   (rd_size),
    .rd_arr    (rd_arr),
    .rd_lru    (rd_lru),
    .cell_occ  (cell_occ),
    .start_hit (start_hit),
    .hit_id    (hit_id),
    .hit_size  (hit_size)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign rd_id   = (state_r == S_PICK) ? pid_r : req_r.process_id;
  assign cand    = policy_r ? rd_lru : rd_arr;
  assign run_inc = run_r + SIZE_W'(1);
  // saturating stamp counter
  assign ctr_inc = (ctr_r == '1) ? ctr_r : ctr_r + STAMP_W'(1);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    keep_nxt      = keep_r;
    idx_nxt       = idx_r;
    run_nxt       = run_r;
    first_nxt     = first_r;
    cursor_nxt    = cursor_r;
    pid_nxt       = pid_r;
    bid_nxt       = bid_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    ctr_nxt       = ctr_r;
    evc_nxt       = evc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr            = '0;
    wr.id         = req_r.process_id;
    wr.start_val  = first_r;
    wr.size_val   = req_r.request_units;
    wr.stamp_val  = ctr_r;
    wr.shd_id     = hit_id;
    wr.shd_val    = cursor_r[CELL_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_item;
          res_nxt   = '0;
          evc_nxt   = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        idx_nxt    = '0;
        run_nxt    = '0;
        cursor_nxt = '0;
        case (req_r.mode)
          MODE_ALLOC: begin
            if (req_r.request_units == '0) begin
              res_nxt.status = ST_BAD_SIZE;
              state_nxt      = S_DONE;
            end else begin
              // release the old cells of a resident id, keep its arrival
              keep_nxt   = resident[req_r.process_id];
              wr.res_we  = 1'b1;
              wr.res_val = 1'b0;
              state_nxt  = S_FIT;
            end
          end
          MODE_FREE: begin
            if (!resident[req_r.process_id]) begin
              res_nxt.status = ST_NOT_RES;
              state_nxt      = S_DONE;
            end else begin
              res_nxt.freed_units = rd_size;
              wr.res_we  = 1'b1;
              wr.res_val = 1'b0;
              state_nxt  = S_CMP;
            end
          end
          MODE_USE: begin
            if (!resident[req_r.process_id]) begin
              res_nxt.status = ST_NOT_RES;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_LRU;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_FIT: begin
        idx_nxt = idx_r + CELL_W'(1);
        if (!cell_occ) begin
          run_nxt = run_inc;
          if (run_r == '0) begin
            first_nxt = idx_r;
          end
        end else begin
          run_nxt = '0;
        end
        if (!cell_occ && run_inc == req_r.request_units) begin
          wr.place_we        = 1'b1;
          wr.res_we          = 1'b1;
          wr.res_val         = 1'b1;
          wr.start_val       = (run_r == '0) ? idx_r : first_r;
          res_nxt.start_unit = wr.start_val;
          state_nxt          = keep_r ? S_LRU : S_ARR;
        end else if (idx_r == LAST_CELL) begin
          if (resident != '0) begin
            pid_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_PICK;
          end else begin
            res_nxt.status = ST_NO_ROOM;
            state_nxt      = S_DONE;
          end
        end
      end
      S_ARR: begin
        wr.arr_we = 1'b1;
        ctr_nxt   = ctr_inc;
        state_nxt = S_LRU;
      end
      S_LRU: begin
        wr.lru_we = 1'b1;
        ctr_nxt   = ctr_inc;
        state_nxt = S_DONE;
      end
      S_PICK: begin
        // strict compare keeps the lowest id on ties
        if (resident[pid_r] && (!found_r || cand < best_r)) begin
          found_nxt = 1'b1;
          best_nxt  = cand;
          bid_nxt   = pid_r;
        end
        pid_nxt = pid_r + ID_W'(1);
        if (pid_r == LAST_ID) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        wr.id      = bid_r;
        wr.res_we  = 1'b1;
        wr.res_val = 1'b0;
        evc_nxt    = evc_r + EVC_W'(1);
        idx_nxt    = '0;
        cursor_nxt = '0;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        idx_nxt = idx_r + CELL_W'(1);
        if (start_hit) begin
          wr.shd_we  = 1'b1;
          cursor_nxt = cursor_r + hit_size;
        end
        if (idx_r == LAST_CELL) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        wr.commit = 1'b1;
        idx_nxt   = '0;
        run_nxt   = '0;
        state_nxt = (req_r.mode == MODE_FREE) ? S_DONE : S_FIT;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt               = res_r;
          out_nxt.evicted_count = evc_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    keep_r   <= keep_nxt;
    idx_r    <= idx_nxt;
    run_r    <= run_nxt;
    first_r  <= first_nxt;
    cursor_r <= cursor_nxt;
    pid_r    <= pid_nxt;
    bid_r    <= bid_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    evc_r    <= evc_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/cae_blocktab.sv @@
// Per-process block table: residency, placement, stamps, compaction shadow.
// Answers cell occupancy and block-start lookups for one cell index. Uses cae_pkg.
`default_nettype none
module cae_blocktab
  import cae_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tab_wr_t              wr,
  input  wire logic [CELL_W-1:0]    cell_idx,
  input  wire logic [ID_W-1:0]      rd_id,
  output logic [MAX_PROCS-1:0]      resident,
  output logic [SIZE_W-1:0]         rd_size,
  output logic [STAMP_W-1:0]        rd_arr,
  output logic [STAMP_W-1:0]        rd_lru,
  output logic                      cell_occ,
  output logic                      start_hit,
  output logic [ID_W-1:0]           hit_id,
  output logic [SIZE_W-1:0]         hit_size
);

  logic [MAX_PROCS-1:0] res_r;
  logic [CELL_W-1:0]    start_r [MAX_PROCS];
  logic [SIZE_W-1:0]    size_r  [MAX_PROCS];
  logic [STAMP_W-1:0]   arr_r   [MAX_PROCS];
  logic [STAMP_W-1:0]   lru_r   [MAX_PROCS];
  logic [CELL_W-1:0]    shd_r   [MAX_PROCS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (wr.res_we) begin
      res_r[wr.id] <= wr.res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.place_we) begin
      size_r[wr.id] <= wr.size_val;
    end
    if (wr.arr_we) begin
      arr_r[wr.id] <= wr.stamp_val;
    end
    if (wr.lru_we) begin
      lru_r[wr.id] <= wr.stamp_val;
    end
    if (wr.shd_we) begin
      shd_r[wr.shd_id] <= wr.shd_val;
    end
    for (int k = 0; k < MAX_PROCS; k++) begin
      if (wr.commit) begin
        start_r[k] <= shd_r[k];
      end else if (wr.place_we && wr.id == ID_W'(k)) begin
        start_r[k] <= wr.start_val;
      end
    end
  end

  assign resident = res_r;
  assign rd_size  = size_r[rd_id];
  assign rd_arr   = arr_r[rd_id];
  assign rd_lru   = lru_r[rd_id];
  assign hit_size = size_r[hit_id];

  // Blocks never overlap, so at most one id covers or starts at a cell
  always_comb begin
    logic [SIZE_W-1:0] blk_end;
    cell_occ  = 1'b0;
    start_hit = 1'b0;
    hit_id    = '0;
    for (int k = 0; k < MAX_PROCS; k++) begin
      blk_end = {1'b0, start_r[k]} + size_r[k];
      if (res_r[k]) begin
        if (cell_idx >= start_r[k] && {1'b0, cell_idx} < blk_end) begin
          cell_occ = 1'b1;
        end
        if (cell_idx == start_r[k]) begin
          start_hit = 1'b1;
          hit_id    = ID_W'(k);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/cae_checker.sv @@
// Port-level checks for the allocator top level, attached by bind.
// Uses cae_pkg.
`default_nettype none
module cae_checker
  import cae_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted an item while busy");

  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.start_unit == '0)
    else $error("start set on failed item");

  a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.freed_units == '0)
    else $error("freed set on failed item");

endmodule

bind contiguous_allocator_with_eviction_unit cae_checker u_cae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

@@ verif/contiguous_allocator_with_eviction_unit_tb.sv @@
// Self-checking bench for contiguous_allocator_with_eviction_unit.
// Depends on cae_pkg; a class tracks cell ownership and predicts each result.
module contiguous_allocator_with_eviction_unit_tb;
  import cae_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [4:0] CELL_FREE = 5'(MAX_PROCS);
  localparam logic [1:0] MODE_SPARE = 2'd3;

  class alloc_tracker;
    logic [4:0]         owner [MEM_UNITS];
    bit                 resident [MAX_PROCS];
    int                 blk_start [MAX_PROCS];
    int                 blk_size [MAX_PROCS];
    logic [STAMP_W-1:0] arrived [MAX_PROCS];
    logic [STAMP_W-1:0] touched [MAX_PROCS];
    logic [STAMP_W-1:0] stamp;
    bit                 use_lru;
    out_item_t          pending_q [$];
    int                 mismatches;

    function void clear();
      foreach (owner[i]) owner[i] = CELL_FREE;
      foreach (resident[i]) begin
        resident[i] = 0;
        blk_start[i] = 0;
        blk_size[i] = 0;
        arrived[i] = '0;
        touched[i] = '0;
      end
      stamp = '0;
      use_lru = 0;
      pending_q.delete();
      mismatches = 0;
    endfunction

    function logic [STAMP_W-1:0] next_stamp();
      logic [STAMP_W-1:0] v;
      v = stamp;
      if (stamp != '1) stamp++;
      return v;
    endfunction

    function bit first_fit(int need, output int where);
      int run;
      run = 0;
      where = 0;
      for (int i = 0; i < MEM_UNITS; i++) begin
        if (owner[i] == CELL_FREE) begin
          if (run == 0) where = i;
          run++;
          if (run == need) return 1;
        end else begin
          run = 0;
        end
      end
      return 0;
    endfunction

    function void drop_block(int id);
      for (int i = 0; i < blk_size[id] && blk_start[id] + i < MEM_UNITS; i++)
        owner[blk_start[id] + i] = CELL_FREE;
      resident[id] = 0;
    endfunction

    // Pack blocks toward cell 0, keeping their order.
    function void pack_cells();
      int cursor;
      logic [4:0] prev, o;
      cursor = 0;
      prev = CELL_FREE;
      for (int i = 0; i < MEM_UNITS; i++) begin
        o = owner[i];
        if (o != CELL_FREE) begin
          if (o != prev) blk_start[o] = cursor;
          owner[cursor] = o;
          cursor++;
        end
        prev = o;
      end
      for (int i = cursor; i < MEM_UNITS; i++) owner[i] = CELL_FREE;
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      int id, size, where, evicted, victim;
      bit ok, keep_arrival, any;
      logic [STAMP_W-1:0] best, s;
      r = '0;
      id = it.process_id;
      size = it.request_units;
      evicted = 0;
      if (it.mode == MODE_ALLOC) begin
        if (size == 0) begin
          r.status = ST_BAD_SIZE;
        end else begin
          keep_arrival = resident[id];
          if (resident[id]) drop_block(id);
          ok = first_fit(size, where);
          forever begin
            if (ok) break;
            any = 0;
            victim = 0;
            best = '0;
            for (int i = 0; i < MAX_PROCS; i++) begin
              if (!resident[i]) continue;
              s = use_lru ? touched[i] : arrived[i];
              if (!any || s < best) begin
                any = 1;
                victim = i;
                best = s;
              end
            end
            if (!any) break;
            drop_block(victim);
            pack_cells();
            evicted++;
            ok = first_fit(size, where);
          end
          if (!ok) begin
            r.status = ST_NO_ROOM;
          end else begin
            for (int i = 0; i < size; i++) owner[where + i] = 5'(id);
            resident[id] = 1;
            blk_start[id] = where;
            blk_size[id] = size;
            if (!keep_arrival) arrived[id] = next_stamp();
            touched[id] = next_stamp();
            r.start_unit = CELL_W'(where);
          end
          r.evicted_count = EVC_W'(evicted);
        end
      end else if (it.mode == MODE_FREE) begin
        if (!resident[id]) begin
          r.status = ST_NOT_RES;
        end else begin
          r.freed_units = SIZE_W'(blk_size[id]);
          drop_block(id);
          pack_cells();
        end
      end else if (it.mode == MODE_USE) begin
        if (!resident[id]) r.status = ST_NOT_RES;
        else touched[id] = next_stamp();
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.status != want.status || got.start_unit != want.start_unit ||
          got.freed_units != want.freed_units ||
          got.evicted_count != want.evicted_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_item;
  out_item_t out_item;
  logic      cfg_we, cfg_wdata;
  bit        calm;
  int        idle_cycles;
  alloc_tracker tracker;

  contiguous_allocator_with_eviction_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts until the quiet tail of the run.
  initial begin
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      out_ready <= 1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(it);
  endtask

  task automatic send_op(logic [1:0] mode, int id, int size);
    in_item_t it;
    it.mode = mode;
    it.process_id = ID_W'(id);
    it.request_units = SIZE_W'(size);
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (tracker.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_policy(bit lru);
    drain();
    cfg_we <= 1;
    cfg_wdata <= lru;
    @(posedge clk);
    cfg_we <= 0;
    tracker.use_lru = lru;
  endtask

  task automatic send_random(int count);
    int pick, size;
    logic [1:0] mode;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      mode = pick < 55 ? MODE_ALLOC : pick < 75 ? MODE_FREE : pick < 95 ? MODE_USE : MODE_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 2) size = 0;
      else if (pick < 5) size = $urandom_range(64, 127);
      else if (pick < 15) size = $urandom_range(17, 63);
      else size = $urandom_range(1, 16);
      send_op(mode, $urandom_range(0, MAX_PROCS - 1), size);
    end
  endtask

  initial begin
    tracker = new();
    tracker.clear();
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    cfg_we = 0;
    cfg_wdata = 0;
    calm = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    set_policy(0);

    // Directed corners.
    send_op(MODE_ALLOC, 3, 0);
    send_op(MODE_FREE, 3, 5);
    send_op(MODE_USE, 3, 5);
    send_op(MODE_SPARE, 15, 127);
    send_op(MODE_ALLOC, 0, 64);
    send_op(MODE_ALLOC, 15, 127);
    send_op(MODE_ALLOC, 1, 10);
    send_op(MODE_ALLOC, 2, 20);
    send_op(MODE_ALLOC, 15, 30);
    send_op(MODE_USE, 1, 0);
    send_op(MODE_ALLOC, 2, 25);
    send_op(MODE_ALLOC, 4, 20);
    send_op(MODE_FREE, 15, 0);
    send_op(MODE_ALLOC, 5, 1);
    send_op(MODE_ALLOC, 6, 63);
    set_policy(1);
    send_op(MODE_ALLOC, 7, 16);
    send_op(MODE_ALLOC, 8, 16);
    send_op(MODE_ALLOC, 9, 16);
    send_op(MODE_USE, 7, 0);
    send_op(MODE_ALLOC, 10, 30);
    send_op(MODE_FREE, 9, 0);
    send_op(MODE_ALLOC, 11, 127);

    send_random(500);
    set_policy(0);
    send_random(500);
    drain();
    send_random(450);
    set_policy(1);
    send_random(300);
    calm = 1;
    send_random(200);

    drain();
    if (tracker.mismatches == 0 && tracker.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
